// ===== design/qrr_pkg.sv =====
// Shared types and constants for the quadratic real-root pipeline.
// Depends on nothing; the top level imports it.
`default_nettype none
package qrr_pkg;

  // Coefficient and result formats are fixed by the payload structs.
  localparam int CoefWidth = 16;
  localparam int RootWidth = 32;
  localparam int RootFracBits = 16;

  // The discriminant magnitude fits in 2W+1 bits, and it is scaled by 2^32
  // before the square root.
  localparam int DiscWidth = 2 * CoefWidth + 1;
  localparam int RadWidth = DiscWidth + 2 * RootFracBits;
  localparam int SqrtWidth = (RadWidth + 1) / 2;

  // -B * 2^16 as a signed value, then the two signed numerators.
  localparam int NegBWidth = CoefWidth + RootFracBits + 1;
  localparam int SumWidth = NegBWidth + 2;
  // Rounding numerator 2|n| + |2A| and rounding denominator 2|2A|.
  localparam int NumWidth = SumWidth + 1;
  localparam int DenWidth = CoefWidth + 2;
  // Quotient bits kept; anything at or above 2^QuotWidth saturates anyway.
  localparam int QuotWidth = RootWidth + 1;

  typedef enum logic [1:0] {
    StNone   = 2'd0,
    StDouble = 2'd1,
    StTwo    = 2'd2,
    StDegen  = 2'd3
  } root_status_e;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_a;
    logic signed [CoefWidth-1:0] coef_b;
    logic signed [CoefWidth-1:0] coef_c;
  } qrr_in_t;

  typedef struct packed {
    root_status_e                root_status;
    logic signed [RootWidth-1:0] root_plus;
    logic signed [RootWidth-1:0] root_minus;
    logic                        saturated;
  } qrr_out_t;

endpackage
`default_nettype wire

// ===== design/qrr_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Standalone; the widths come from its parameters.
`default_nettype none
module qrr_isqrt #(
  parameter int RadW  = 65,
  parameter int SideW = 34
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [RadW-1:0]           rad_i,
  input  wire logic [SideW-1:0]          side_i,
  output logic                           valid_o,
  output logic [(RadW+1)/2-1:0]          root_o,
  output logic [SideW-1:0]               side_o
);

  localparam int RootW = (RadW + 1) / 2;
  localparam int TrialW = RadW + 2;

  logic             valid_s [RootW+1];
  logic [RadW-1:0]  rem_s   [RootW+1];
  logic [RootW-1:0] root_s  [RootW+1];
  logic [SideW-1:0] side_s  [RootW+1];

  assign valid_s[0] = valid_i;
  assign rem_s[0]   = rad_i;
  assign root_s[0]  = '0;
  assign side_s[0]  = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic [TrialW-1:0] trial;
    logic [TrialW-1:0] rem_ext;
    logic              take;
    logic              valid_q;
    logic [RadW-1:0]   rem_q;
    logic [RootW-1:0]  root_q;
    logic [SideW-1:0]  side_q;

    // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
    assign trial   = (TrialW'(root_s[k]) << (Bit + 1)) | (TrialW'(1) << (2 * Bit));
    assign rem_ext = TrialW'(rem_s[k]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? RadW'(rem_ext - trial) : rem_s[k];
        root_q <= take ? (root_s[k] | (RootW'(1) << Bit)) : root_s[k];
        side_q <= side_s[k];
      end
    end

    assign valid_s[k+1] = valid_q;
    assign rem_s[k+1]   = rem_q;
    assign root_s[k+1]  = root_q;
    assign side_s[k+1]  = side_q;
  end

  assign valid_o = valid_s[RootW];
  assign root_o  = root_s[RootW];
  assign side_o  = side_s[RootW];

endmodule
`default_nettype wire

// ===== design/qrr_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with an
// overflow flag for quotients that do not fit. Standalone.
`default_nettype none
module qrr_div #(
  parameter int NumW  = 36,
  parameter int DenW  = 18,
  parameter int QuotW = 33,
  parameter int SideW = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DenW-1:0]   den_i,
  input  wire logic [SideW-1:0]  side_i,
  output logic                   valid_o,
  output logic [QuotW-1:0]       quot_o,
  output logic                   ovf_o,
  output logic [SideW-1:0]       side_o
);

  localparam int CmpW = (NumW > DenW + QuotW) ? NumW + 1 : DenW + QuotW + 1;

  logic             valid_s [QuotW+1];
  logic [NumW-1:0]  rem_s   [QuotW+1];
  logic [DenW-1:0]  den_s   [QuotW+1];
  logic [QuotW-1:0] quot_s  [QuotW+1];
  logic             ovf_s   [QuotW+1];
  logic [SideW-1:0] side_s  [QuotW+1];

  assign valid_s[0] = valid_i;
  assign rem_s[0]   = num_i;
  assign den_s[0]   = den_i;
  assign quot_s[0]  = '0;
  assign ovf_s[0]   = CmpW'(num_i) >= (CmpW'(den_i) << QuotW);
  assign side_s[0]  = side_i;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int Bit = QuotW - 1 - k;
    logic [CmpW-1:0]  trial;
    logic [CmpW-1:0]  rem_ext;
    logic             take;
    logic             valid_q;
    logic [NumW-1:0]  rem_q;
    logic [DenW-1:0]  den_q;
    logic [QuotW-1:0] quot_q;
    logic             ovf_q;
    logic [SideW-1:0] side_q;

    assign trial   = CmpW'(den_s[k]) << Bit;
    assign rem_ext = CmpW'(rem_s[k]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? NumW'(rem_ext - trial) : rem_s[k];
        den_q  <= den_s[k];
        quot_q <= take ? (quot_s[k] | (QuotW'(1) << Bit)) : quot_s[k];
        ovf_q  <= ovf_s[k];
        side_q <= side_s[k];
      end
    end

    assign valid_s[k+1] = valid_q;
    assign rem_s[k+1]   = rem_q;
    assign den_s[k+1]   = den_q;
    assign quot_s[k+1]  = quot_q;
    assign ovf_s[k+1]   = ovf_q;
    assign side_s[k+1]  = side_q;
  end

  assign valid_o = valid_s[QuotW];
  assign quot_o  = quot_s[QuotW];
  assign ovf_o   = ovf_s[QuotW];
  assign side_o  = side_s[QuotW];

endmodule
`default_nettype wire

// ===== design/quadratic_real_roots_top.sv =====
// Top level of the quadratic real-root pipeline.
// Depends on qrr_pkg, qrr_isqrt and qrr_div.
`default_nettype none
// Real roots of A*x^2 + B*x + C in signed Q16.16 from three signed 16-bit
// coefficients. The block is a fully pipelined datapath: it accepts one item
// per clock while the output is not stalled, and passes each item through two
// discriminant stages, 33 square-root stages, one numerator stage, 33 divider
// stages and the output register. The square root and the two dividers resolve
// one bit per stage, which sets the depth. A stall on a valid output freezes
// the whole pipe and the input in the same cycle; no item is lost or repeated.
module quadratic_real_roots_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire qrr_pkg::qrr_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output qrr_pkg::qrr_out_t     out_data_o
);

  import qrr_pkg::*;

  localparam int W = CoefWidth;
  localparam int ProdW = 2 * W;
  localparam int SqrtSideW = 2 + 2 * W;
  localparam int DivSideW = 3;

  logic en;
  logic out_valid_q;
  qrr_out_t out_data_q;

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: magnitudes and the two products.
  logic [W-1:0] abs_a, abs_b, abs_c;
  assign abs_a = in_data_i.coef_a[W-1] ? W'(-in_data_i.coef_a) : in_data_i.coef_a;
  assign abs_b = in_data_i.coef_b[W-1] ? W'(-in_data_i.coef_b) : in_data_i.coef_b;
  assign abs_c = in_data_i.coef_c[W-1] ? W'(-in_data_i.coef_c) : in_data_i.coef_c;

  logic             v1_q;
  logic [ProdW-1:0] bb1_q, ac1_q;
  logic             opp1_q, azero1_q;
  logic [W-1:0]     a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb1_q    <= ProdW'(abs_b) * ProdW'(abs_b);
      ac1_q    <= ProdW'(abs_a) * ProdW'(abs_c);
      // With A and C of opposite sign, -4AC is positive and adds to B^2.
      opp1_q   <= (abs_c != '0) && (in_data_i.coef_a[W-1] != in_data_i.coef_c[W-1]);
      azero1_q <= (in_data_i.coef_a == '0);
      a1_q     <= in_data_i.coef_a;
      b1_q     <= in_data_i.coef_b;
    end
  end

  // Stage 2: discriminant and classification.
  logic [DiscWidth-1:0] bb_ext, ac4_ext, disc;
  root_status_e         status2;

  assign bb_ext  = DiscWidth'(bb1_q);
  assign ac4_ext = DiscWidth'(ac1_q) << 2;

  always_comb begin
    disc = '0;
    priority if (azero1_q) begin
      status2 = StDegen;
    end else if (opp1_q) begin
      status2 = StTwo;
      disc    = bb_ext + ac4_ext;
    end else if (bb_ext > ac4_ext) begin
      status2 = StTwo;
      disc    = bb_ext - ac4_ext;
    end else if (bb_ext == ac4_ext) begin
      status2 = StDouble;
    end else begin
      status2 = StNone;
    end
  end

  logic                 v2_q;
  logic [DiscWidth-1:0] disc2_q;
  root_status_e         status2_q;
  logic [W-1:0]         a2_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc2_q   <= disc;
      status2_q <= status2;
      a2_q      <= a1_q;
      b2_q      <= b1_q;
    end
  end

  // Square root of D * 2^32.
  logic                 vs;
  logic [SqrtWidth-1:0] sq_root;
  logic [SqrtSideW-1:0] sq_side;

  qrr_isqrt #(
    .RadW  (RadWidth),
    .SideW (SqrtSideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   ({disc2_q, (2 * RootFracBits)'(0)}),
    .side_i  ({status2_q, a2_q, b2_q}),
    .valid_o (vs),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage 3: signed numerators and the rounding operands.
  root_status_e           status_s;
  logic signed [W-1:0]    a_s, b_s;
  logic [W-1:0]           abs_as;
  logic signed [NegBWidth-1:0] neg_b;
  logic signed [SumWidth-1:0]  num_p, num_m;
  logic [SumWidth-1:0]    mag_p, mag_m;

  assign status_s = root_status_e'(sq_side[SqrtSideW-1 -: 2]);
  assign a_s      = sq_side[2*W-1 -: W];
  assign b_s      = sq_side[W-1:0];
  assign abs_as   = a_s[W-1] ? W'(-a_s) : a_s;
  assign neg_b    = -(NegBWidth'(b_s) <<< RootFracBits);
  assign num_p    = SumWidth'(neg_b) + $signed(SumWidth'(sq_root));
  assign num_m    = SumWidth'(neg_b) - $signed(SumWidth'(sq_root));
  assign mag_p    = num_p[SumWidth-1] ? SumWidth'(-num_p) : num_p;
  assign mag_m    = num_m[SumWidth-1] ? SumWidth'(-num_m) : num_m;

  logic                v3_q;
  logic [NumWidth-1:0] nump3_q, numm3_q;
  logic [DenWidth-1:0] den3_q;
  root_status_e        status3_q;
  logic                negp3_q, negm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vs;
    end
  end

  // Rounding to nearest with ties away from zero: (2|n| + |d|) / (2|d|), d = 2A.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nump3_q   <= {mag_p, 1'b0} + NumWidth'({abs_as, 1'b0});
      numm3_q   <= {mag_m, 1'b0} + NumWidth'({abs_as, 1'b0});
      den3_q    <= {abs_as, 2'b00};
      status3_q <= status_s;
      negp3_q   <= num_p[SumWidth-1] != a_s[W-1];
      negm3_q   <= num_m[SumWidth-1] != a_s[W-1];
    end
  end

  logic                 vdp, vdm;
  logic [QuotWidth-1:0] qp, qm;
  logic                 ovfp, ovfm;
  logic [DivSideW-1:0]  sidep, sidem;

  qrr_div #(
    .NumW  (NumWidth),
    .DenW  (DenWidth),
    .QuotW (QuotWidth),
    .SideW (DivSideW)
  ) u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (nump3_q),
    .den_i   (den3_q),
    .side_i  ({status3_q, negp3_q}),
    .valid_o (vdp),
    .quot_o  (qp),
    .ovf_o   (ovfp),
    .side_o  (sidep)
  );

  qrr_div #(
    .NumW  (NumWidth),
    .DenW  (DenWidth),
    .QuotW (QuotWidth),
    .SideW (DivSideW)
  ) u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (numm3_q),
    .den_i   (den3_q),
    .side_i  ({status3_q, negm3_q}),
    .valid_o (vdm),
    .quot_o  (qm),
    .ovf_o   (ovfm),
    .side_o  (sidem)
  );

  // Final stage: sign and saturation.
  localparam logic [QuotWidth-1:0] NegLimit = QuotWidth'(1) << (RootWidth - 1);
  localparam logic [QuotWidth-1:0] PosLimit = NegLimit - QuotWidth'(1);
  localparam logic [RootWidth-1:0] NegSat = RootWidth'(NegLimit);
  localparam logic [RootWidth-1:0] PosSat = RootWidth'(PosLimit);

  root_status_e         status_f;
  logic                 negp_f, negm_f, satp, satm;
  logic [RootWidth-1:0] rootp, rootm;
  qrr_out_t             out_d;

  assign status_f = root_status_e'(sidep[DivSideW-1 -: 2]);
  assign negp_f   = sidep[0];
  assign negm_f   = sidem[0];
  assign satp     = ovfp || (negp_f ? (qp > NegLimit) : (qp > PosLimit));
  assign satm     = ovfm || (negm_f ? (qm > NegLimit) : (qm > PosLimit));
  assign rootp    = satp ? (negp_f ? NegSat : PosSat)
                         : (negp_f ? RootWidth'(-qp) : RootWidth'(qp));
  assign rootm    = satm ? (negm_f ? NegSat : PosSat)
                         : (negm_f ? RootWidth'(-qm) : RootWidth'(qm));

  always_comb begin
    out_d.root_status = status_f;
    unique case (status_f)
      StDouble, StTwo: begin
        out_d.root_plus  = rootp;
        out_d.root_minus = rootm;
        out_d.saturated  = satp || satm;
      end
      default: begin
        out_d.root_plus  = '0;
        out_d.root_minus = '0;
        out_d.saturated  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vdp && vdm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The two dividers must stay in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) vdp == vdm)
    else $error("divider valid bits out of step");

  // A double root gives equal roots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.root_status == StDouble |->
      out_data_q.root_plus == out_data_q.root_minus)
    else $error("double root with unequal roots");

  // No root and degenerate items carry zero roots and no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.root_status == StNone || out_data_q.root_status == StDegen)
      |-> out_data_q.root_plus == '0 && out_data_q.root_minus == '0
          && !out_data_q.saturated)
    else $error("nonzero roots without real roots");

  // A held result keeps the pipe frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed");

endmodule
`default_nettype wire
